>>> hw/rtl/assert_macros.svh
// assertion helpers for the lens map checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CHK_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CHK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ldfm_pkg.sv
package ldfm_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    REG_FOCAL      = 4'd0,
    REG_CENTER     = 4'd1,
    REG_SKEW       = 4'd2,
    REG_K1         = 4'd3,
    REG_K2         = 4'd4,
    REG_K3         = 4'd5,
    REG_TANGENTIAL = 4'd6,
    REG_IMAGE_SIZE = 4'd7
  } reg_index_t;

  localparam int CFG_DATA_W = 48;
  localparam int LATENCY    = 12;

  typedef struct packed {
    logic signed [23:0] norm_x;
    logic signed [23:0] norm_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pix_u;
    logic signed [31:0] pix_v;
    status_t            status;
  } out_item_t;

endpackage

>>> hw/rtl/lens_distortion_forward_map_top.sv
// lens distortion forward map: normalized point (Q4.20) to distorted pixel (Q22.10)
//
// input channel: drive point and pulse start; a transaction is taken at an edge
// where start is high and busy is low. busy stays low outside reset, so a new
// point may be started every clock.
// output channel: done is high for one cycle with result valid in that cycle.
// there is no backpressure; the receiver must take every result as it comes.
// throughput: one point per clock, set by the 12-stage multiplier pipeline
// (squares, radial powers r4 and r6, the distortion polynomial, the focal term).
// config: cfg_index/cfg_data written when cfg_valid is high (cfg_ready is
// high outside reset); write only while no point is in flight. unknown indexes
// are ignored.
// reset: rst is synchronous; all coefficients return to zero and any points
// in flight are dropped, no done follows.
// status: ok, illegal focal length (u and v forced to zero) or out of range
// (u and v still carry the mapped point).
module lens_distortion_forward_map_top
  import ldfm_pkg::*;
#(
  parameter int RANGE_RATIO_Q8 = 384
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              point,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output out_item_t             result
);

  localparam logic signed [11:0] RATIO_HI = 12'(RANGE_RATIO_Q8);
  localparam logic signed [11:0] RATIO_LO = 12'(256 - RANGE_RATIO_Q8);

  // configuration
  logic [23:0]        fu, fv, u0, v0;
  logic signed [23:0] skew, k1, k2, k3, p1, p2;
  logic [15:0]        img_w, img_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      fu <= '0; fv <= '0; u0 <= '0; v0 <= '0;
      skew <= '0; k1 <= '0; k2 <= '0; k3 <= '0; p1 <= '0; p2 <= '0;
      img_w <= '0; img_h <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FOCAL: begin
          fu <= cfg_data[23:0];
          fv <= cfg_data[47:24];
        end
        REG_CENTER: begin
          u0 <= cfg_data[23:0];
          v0 <= cfg_data[47:24];
        end
        REG_SKEW: skew <= $signed(cfg_data[23:0]);
        REG_K1:   k1 <= $signed(cfg_data[23:0]);
        REG_K2:   k2 <= $signed(cfg_data[23:0]);
        REG_K3:   k3 <= $signed(cfg_data[23:0]);
        REG_TANGENTIAL: begin
          p1 <= $signed(cfg_data[23:0]);
          p2 <= $signed(cfg_data[47:24]);
        end
        REG_IMAGE_SIZE: begin
          img_w <= cfg_data[15:0];
          img_h <= cfg_data[31:16];
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready = !rst;
  assign busy      = rst;

  logic accept;
  assign accept = start && !busy;

  logic vld [1:LATENCY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LATENCY; i++) vld[i] <= 1'b0;
    end else begin
      vld[1] <= accept;
      for (int i = 2; i <= LATENCY; i++) vld[i] <= vld[i-1];
    end
  end

  assign done = vld[LATENCY];

  // stage registers
  logic signed [23:0] x1, y1;
  logic signed [47:0] xx2, yy2, xy2, fx2, fy2, sky2;
  logic [27:0]        r2_3, r2_4, r2_5;
  logic [29:0]        qx3, qy3;
  logic signed [27:0] xy20_3;
  logic signed [49:0] posu3, posv3;
  logic signed [47:0] fx3, fy3, sky3;
  logic [55:0]        r2sq4;
  logic signed [52:0] k1r2_4, k1r2_5, k1r2_6;
  logic signed [54:0] tua4, tva4;
  logic signed [51:0] tub4, tvb4;
  logic signed [50:0] linu4, linv4;
  logic [31:0]        r4_5, r6_7;
  logic [59:0]        r4r2_6;
  logic signed [56:0] k2r4_6, k3r6_8;
  logic signed [57:0] ksum7, ksum8;
  logic signed [25:0] d9;
  logic signed [63:0] fdu10, fdv10;
  logic signed [57:0] au11, av11;

  logic signed [37:0] fx20_p [3:9];
  logic signed [37:0] fy20_p [3:9];
  logic signed [56:0] tanu_p [5:10];
  logic signed [56:0] tanv_p [5:10];
  logic               oob_p  [4:11];
  logic               ill_p  [2:11];

  // combinational pieces
  logic signed [49:0] r2r, qxr, qyr, posu_c, posv_c;
  logic signed [48:0] xyr, fxr, fyr;
  logic signed [28:0] hiu_m, lou_m, hiv_m, lov_m;
  logic signed [50:0] hiu, lou, hiv, lov;
  logic [56:0]        r4t;
  logic [36:0]        r4s;
  logic [60:0]        r6t;
  logic [40:0]        r6s;
  logic signed [59:0] dt;
  logic signed [39:0] ds;
  logic signed [63:0] fur, fvr;
  logic signed [58:0] aur, avr;
  logic signed [38:0] aus, avs;
  logic signed [31:0] u_sat, v_sat;

  always_comb begin
    r2r = 50'(xx2) + 50'(yy2) + 50'sd524288;
    qxr = (50'(xx2) <<< 1) + 50'(xx2) + 50'(yy2) + 50'sd524288;
    qyr = (50'(yy2) <<< 1) + 50'(yy2) + 50'(xx2) + 50'sd524288;
    xyr = 49'(xy2) + 49'sd524288;
    fxr = 49'(fx2) + 49'sd512;
    fyr = 49'(fy2) + 49'sd512;
    posu_c = 50'(fx2) + $signed({6'b0, u0, 20'b0});
    posv_c = 50'(fy2) + $signed({6'b0, v0, 20'b0});

    // bounds in Q.30: size * ratio / 256
    hiu_m = $signed({1'b0, img_w}) * RATIO_HI;
    lou_m = $signed({1'b0, img_w}) * RATIO_LO;
    hiv_m = $signed({1'b0, img_h}) * RATIO_HI;
    lov_m = $signed({1'b0, img_h}) * RATIO_LO;
    hiu = $signed({hiu_m, 22'b0});
    lou = $signed({lou_m, 22'b0});
    hiv = $signed({hiv_m, 22'b0});
    lov = $signed({lov_m, 22'b0});

    r4t = {1'b0, r2sq4} + 57'd524288;
    r4s = r4t[56:20];
    r6t = {1'b0, r4r2_6} + 61'd524288;
    r6s = r6t[60:20];

    dt = 60'(ksum8) + 60'(k3r6_8) + 60'sd524288;
    ds = $signed(dt[59:20]);

    fur = fdu10 + 64'sd512;
    fvr = fdv10 + 64'sd512;

    aur = 59'(au11) + 59'sd524288;
    avr = 59'(av11) + 59'sd524288;
    aus = $signed(aur[58:20]);
    avs = $signed(avr[58:20]);
    if (aus > 39'sd2147483647)       u_sat = 32'sh7FFFFFFF;
    else if (aus < -39'sd2147483648) u_sat = 32'sh80000000;
    else                             u_sat = aus[31:0];
    if (avs > 39'sd2147483647)       v_sat = 32'sh7FFFFFFF;
    else if (avs < -39'sd2147483648) v_sat = 32'sh80000000;
    else                             v_sat = avs[31:0];
  end

  always_ff @(posedge clk) begin
    // 1: input register
    x1 <= point.norm_x;
    y1 <= point.norm_y;
    // 2: products of the point
    xx2  <= x1 * x1;
    yy2  <= y1 * y1;
    xy2  <= x1 * y1;
    fx2  <= $signed({1'b0, fu}) * x1;
    fy2  <= $signed({1'b0, fv}) * y1;
    sky2 <= skew * y1;
    ill_p[2] <= (fu == '0) || (fv == '0);
    // 3: rounding to Q.20
    r2_3   <= r2r[47:20];
    qx3    <= qxr[49:20];
    qy3    <= qyr[49:20];
    xy20_3 <= xyr[47:20];
    fx20_p[3] <= fxr[47:10];
    fy20_p[3] <= fyr[47:10];
    posu3 <= posu_c;
    posv3 <= posv_c;
    fx3   <= fx2;
    fy3   <= fy2;
    sky3  <= sky2;
    // 4: r2 squared, k1 term, tangential products, bound test
    r2sq4  <= r2_3 * r2_3;
    k1r2_4 <= k1 * $signed({1'b0, r2_3});
    tua4   <= p1 * $signed({1'b0, qx3});
    tub4   <= p2 * xy20_3;
    tva4   <= p2 * $signed({1'b0, qy3});
    tvb4   <= p1 * xy20_3;
    linu4  <= 51'(fx3) + 51'(sky3) + $signed({7'b0, u0, 20'b0});
    linv4  <= 51'(fy3) + $signed({7'b0, v0, 20'b0});
    oob_p[4] <= (51'(posu3) > hiu) || (51'(posu3) < lou) ||
                (51'(posv3) > hiv) || (51'(posv3) < lov);
    r2_4 <= r2_3;
    // 5: r4, linear plus tangential sum
    r4_5 <= (r4s > 37'h0FFFFFFFF) ? 32'hFFFFFFFF : r4s[31:0];
    tanu_p[5] <= 57'(linu4) + 57'(tua4) + (57'(tub4) <<< 1);
    tanv_p[5] <= 57'(linv4) + 57'(tva4) + (57'(tvb4) <<< 1);
    r2_5   <= r2_4;
    k1r2_5 <= k1r2_4;
    // 6: r4*r2, k2 term
    r4r2_6 <= r4_5 * r2_5;
    k2r4_6 <= k2 * $signed({1'b0, r4_5});
    k1r2_6 <= k1r2_5;
    // 7: r6, partial polynomial
    r6_7  <= (r6s > 41'h0FFFFFFFF) ? 32'hFFFFFFFF : r6s[31:0];
    ksum7 <= 58'(k1r2_6) + 58'(k2r4_6);
    // 8: k3 term
    k3r6_8 <= k3 * $signed({1'b0, r6_7});
    ksum8  <= ksum7;
    // 9: distortion factor, saturated
    if (ds > 40'sd33554431)       d9 <= 26'sh1FFFFFF;
    else if (ds < -40'sd33554432) d9 <= 26'sh2000000;
    else                          d9 <= ds[25:0];
    // 10: focal term times distortion
    fdu10 <= fx20_p[9] * d9;
    fdv10 <= fy20_p[9] * d9;
    // 11: final sums in Q.30
    au11 <= 58'(tanu_p[10]) + 58'($signed(fur[63:10]));
    av11 <= 58'(tanv_p[10]) + 58'($signed(fvr[63:10]));
    // 12: output register
    if (ill_p[11]) begin
      result.pix_u  <= '0;
      result.pix_v  <= '0;
      result.status <= ST_ILLEGAL;
    end else begin
      result.pix_u  <= u_sat;
      result.pix_v  <= v_sat;
      result.status <= oob_p[11] ? ST_RANGE : ST_OK;
    end

    for (int i = 4; i <= 9; i++) begin
      fx20_p[i] <= fx20_p[i-1];
      fy20_p[i] <= fy20_p[i-1];
    end
    for (int i = 6; i <= 10; i++) begin
      tanu_p[i] <= tanu_p[i-1];
      tanv_p[i] <= tanv_p[i-1];
    end
    for (int i = 5; i <= 11; i++) oob_p[i] <= oob_p[i-1];
    for (int i = 3; i <= 11; i++) ill_p[i] <= ill_p[i-1];
  end

endmodule

>>> hw/rtl/ldfm_checker.sv
`include "assert_macros.svh"

module ldfm_checker
  import ldfm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input out_item_t result
);

  // every accepted transaction yields its result after the fixed latency
  `CHK_RUN(a_latency, (start && !busy) |-> ##12 done, "result missing after accept")

  // no result without a matching accept
  `CHK_RUN(a_no_spurious, done |-> $past(start && !busy, 12), "result without accept")

  // illegal focal length forces a zero point
  `CHK_RUN(a_illegal_zero,
    (done && result.status == ST_ILLEGAL) |-> (result.pix_u == 0 && result.pix_v == 0),
    "illegal status with nonzero point")

  // reset flushes the pipeline
  `CHK_ALL(a_reset_flush, rst |=> !done, "result right after reset")

endmodule

bind lens_distortion_forward_map_top ldfm_checker u_ldfm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

>>> dv/tb_lens_distortion_forward_map_top.sv
module tb_lens_distortion_forward_map_top;
  import ldfm_pkg::*;

  localparam int RATIO_Q8 = 384;
  localparam int CYCLE_LIMIT = 300000;
  localparam longint D_HI = 64'sd33554431;
  localparam longint D_LO = -64'sd33554432;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  in_item_t              point;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [3:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  done;
  out_item_t             result;

  lens_distortion_forward_map_top #(.RANGE_RATIO_Q8(RATIO_Q8)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  in_item_t    point_q[$];
  out_item_t   expected_maps[$];
  logic [47:0] cam_regs[8];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic longint rnd(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit off_image(longint pos30, longint size);
    longint hi, lo;
    hi = size * RATIO_Q8 * 4194304;
    lo = size * (256 - RATIO_Q8) * 4194304;
    return pos30 > hi || pos30 < lo;
  endfunction

  // brown-conrady forward map in fixed point
  function automatic out_item_t map_point(in_item_t pt);
    longint x, y, fu, fv, u0, v0, skew, k1, k2, k3, p1, p2, w, h;
    longint x2, y2, r2w, r2, r4, r6, d, fx30, fy30, fx20, fy20, xy20, qx, qy, au, av;
    out_item_t m;
    x = pt.norm_x;
    y = pt.norm_y;
    fu = cam_regs[REG_FOCAL][23:0];
    fv = cam_regs[REG_FOCAL][47:24];
    u0 = cam_regs[REG_CENTER][23:0];
    v0 = cam_regs[REG_CENTER][47:24];
    skew = $signed(cam_regs[REG_SKEW][23:0]);
    k1 = $signed(cam_regs[REG_K1][23:0]);
    k2 = $signed(cam_regs[REG_K2][23:0]);
    k3 = $signed(cam_regs[REG_K3][23:0]);
    p1 = $signed(cam_regs[REG_TANGENTIAL][23:0]);
    p2 = $signed(cam_regs[REG_TANGENTIAL][47:24]);
    w = cam_regs[REG_IMAGE_SIZE][15:0];
    h = cam_regs[REG_IMAGE_SIZE][31:16];
    if (fu == 0 || fv == 0) begin
      m.pix_u = '0;
      m.pix_v = '0;
      m.status = ST_ILLEGAL;
      return m;
    end
    x2 = x * x;
    y2 = y * y;
    r2w = x2 + y2;
    r2 = rnd(r2w, 20);
    r4 = rnd(r2 * r2, 20);
    if (r4 > 64'sd4294967295) r4 = 64'sd4294967295;
    r6 = rnd(r4 * r2, 20);
    if (r6 > 64'sd4294967295) r6 = 64'sd4294967295;
    d = clamp(rnd(k1 * r2 + k2 * r4 + k3 * r6, 20), D_LO, D_HI);
    fx30 = fu * x;
    fy30 = fv * y;
    fx20 = rnd(fx30, 10);
    fy20 = rnd(fy30, 10);
    xy20 = rnd(x * y, 20);
    qx = rnd(r2w + 2 * x2, 20);
    qy = rnd(r2w + 2 * y2, 20);
    au = fx30 + u0 * 1048576 + skew * y + rnd(fx20 * d, 10) + p1 * qx + 2 * p2 * xy20;
    av = fy30 + v0 * 1048576 + rnd(fy20 * d, 10) + p2 * qy + 2 * p1 * xy20;
    m.pix_u = 32'(clamp(rnd(au, 20), -64'sd2147483648, 64'sd2147483647));
    m.pix_v = 32'(clamp(rnd(av, 20), -64'sd2147483648, 64'sd2147483647));
    m.status = (off_image(fx30 + u0 * 1048576, w) || off_image(fy30 + v0 * 1048576, h)) ?
               ST_RANGE : ST_OK;
    return m;
  endfunction

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      point <= '0;
    end else begin
      if (start && !busy) expected_maps.push_back(map_point(point));
      if (start && busy) begin
        // hold the transaction
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (point_q.size() > 0) begin
        start <= 1'b1;
        point <= point_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_m;
    if (!rst && done) begin
      if (expected_maps.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_m = expected_maps.pop_front();
        if (result.pix_u !== exp_m.pix_u)
          report($sformatf("pix_u got %0d exp %0d", result.pix_u, exp_m.pix_u));
        if (result.pix_v !== exp_m.pix_v)
          report($sformatf("pix_v got %0d exp %0d", result.pix_v, exp_m.pix_v));
        if (result.status !== exp_m.status)
          report($sformatf("status got %0d exp %0d", result.status, exp_m.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < 8) begin
      case (idx)
        REG_SKEW, REG_K1, REG_K2, REG_K3: cam_regs[idx] = {24'd0, val[23:0]};
        REG_IMAGE_SIZE:                   cam_regs[idx] = {16'd0, val[31:0]};
        default:                          cam_regs[idx] = val;
      endcase
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (point_q.size() != 0 || start || expected_maps.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [23:0] srand24(int mag);
    return 24'($urandom_range(0, 2 * mag) - mag);
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic typical_setup();
    write_reg(REG_FOCAL, {24'($urandom_range(300, 900) << 10), 24'($urandom_range(300, 900) << 10)});
    write_reg(REG_CENTER, {24'($urandom_range(200, 280) << 10), 24'($urandom_range(280, 360) << 10)});
    write_reg(REG_SKEW, {24'd0, srand24(1024)});
    write_reg(REG_K1, {24'd0, srand24(300000)});
    write_reg(REG_K2, {24'd0, srand24(100000)});
    write_reg(REG_K3, {24'd0, srand24(30000)});
    write_reg(REG_TANGENTIAL, {srand24(2048), srand24(2048)});
    write_reg(REG_IMAGE_SIZE, {16'd0, 16'd480, 16'd640});
    write_reg(4'($urandom_range(8, 15)), rand48());
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pt(int x, int y);
    in_item_t pt;
    pt.norm_x = 24'(x);
    pt.norm_y = 24'(y);
    point_q.push_back(pt);
  endtask

  task automatic directed_points();
    push_pt(0, 0);
    push_pt(8388607, 8388607);
    push_pt(-8388608, -8388608);
    push_pt(8388607, -8388608);
    push_pt(-8388608, 8388607);
    push_pt(1048576, 0);
    push_pt(0, -1048576);
    push_pt(262144, 131072);
    push_pt(-300000, 200000);
    push_pt(4000000, 0);
    push_pt(0, 4000000);
    push_pt(-1, 1);
  endtask

  task automatic random_points(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) push_pt($urandom_range(0, 1048575) - 524288, $urandom_range(0, 786431) - 393216);
      else if (sel < 9) push_pt($urandom, $urandom);
      else push_pt($urandom_range(0, 1) ? 8388607 : -8388608, $urandom);
    end
  endtask

  initial begin
    int kind;
    rst = 1'b1;
    start = 1'b0;
    point = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (cam_regs[i]) cam_regs[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // coefficients still at reset: zero focal length
    directed_points();
    wait_idle();

    typical_setup();
    directed_points();
    random_points(12);
    wait_idle();

    // extreme coefficient sets
    for (int i = 0; i < 8; i++) write_reg(i[3:0], '1);
    cfg_valid <= 1'b0;
    directed_points();
    random_points(40);
    wait_idle();
    write_reg(REG_FOCAL, {24'hffffff, 24'hffffff});
    write_reg(REG_CENTER, {24'hffffff, 24'd0});
    write_reg(REG_SKEW, {24'd0, 24'h7fffff});
    write_reg(REG_K1, {24'd0, 24'h800000});
    write_reg(REG_K2, {24'd0, 24'h7fffff});
    write_reg(REG_K3, {24'd0, 24'h800000});
    write_reg(REG_TANGENTIAL, {24'h7fffff, 24'h800000});
    write_reg(REG_IMAGE_SIZE, {16'd0, 16'hffff, 16'd0});
    cfg_valid <= 1'b0;
    directed_points();
    random_points(40);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      kind = $urandom_range(0, 3);
      typical_setup();
      if (kind == 1) begin
        for (int i = 0; i < 8; i++) write_reg(i[3:0], rand48());
        cfg_valid <= 1'b0;
      end else if (kind == 2) begin
        write_reg(REG_FOCAL, {$urandom_range(0, 1) ? 24'd0 : 24'(512000), 24'd0});
        cfg_valid <= 1'b0;
      end
      random_points(kind == 0 || kind == 3 ? 300 : 120);
      wait_idle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
